>>> rtl/i2cbb_pkg.sv
// Shared types and constants for the bit-banged I2C master.
package i2cbb_pkg;

   localparam int TICK_COUNTER_WIDTH = 16;
   localparam int BITS_PER_BYTE      = 8;
   localparam int CFG_DATA_WIDTH     = 16;
   localparam int CFG_INDEX_WIDTH    = 2;
   localparam int BIT_INDEX_WIDTH    = 4;

   typedef logic [TICK_COUNTER_WIDTH-1:0] tick_type;

   typedef enum logic [2:0] {
      OP_START    = 3'd0,
      OP_STOP     = 3'd1,
      OP_WRITE    = 3'd2,
      OP_READ     = 3'd3,
      OP_WAIT_ACK = 3'd4
   } opcode_type;

   typedef enum logic [CFG_INDEX_WIDTH-1:0] {
      CFG_BIT_HALF    = 2'd0,
      CFG_START_STOP  = 2'd1,
      CFG_ACK_SETUP   = 2'd2,
      CFG_RETRY_LIMIT = 2'd3
   } cfg_index_type;

   localparam logic [15:0] BIT_HALF_RESET    = 16'd100;
   localparam logic [15:0] START_STOP_RESET  = 16'd200;
   localparam logic [15:0] ACK_SETUP_RESET   = 16'd50;
   localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd250;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] opcode;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_sample;
   } i2cbb_req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       cmd_done;
      logic [7:0] rx_byte;
      logic       ack_seen;
   } i2cbb_rsp_type;

   // mask to the counter width; zero lasts one tick
   function automatic tick_type delay_of(input logic [15:0] d);
      tick_type v;
      v = TICK_COUNTER_WIDTH'(d);
      if (v == '0) begin
         v = TICK_COUNTER_WIDTH'(1);
      end
      return v;
   endfunction

endpackage

>>> rtl/i2c_bitbang_master_unit.sv
// Top level of the bit-banged I2C master sequencer.
//
// Each accepted request beat is one timing tick: it carries an optional command and the
// sampled SDA level, and produces exactly one response beat with the line levels and
// status after that tick. One beat is taken each clock cycle while req_ready is high;
// the response is in the output register next cycle, and req_ready falls only while
// it holds a beat the consumer has not taken. Commands offered while busy are ignored.
// Delay registers count ticks, not clocks; a zero delay lasts one tick.
module i2c_bitbang_master_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  i2cbb_pkg::i2cbb_req_type           req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output i2cbb_pkg::i2cbb_rsp_type           rsp_data,
   input  logic                               csr_we,
   input  logic [i2cbb_pkg::CFG_INDEX_WIDTH-1:0] csr_index,
   input  logic [i2cbb_pkg::CFG_DATA_WIDTH-1:0]  csr_wdata
);
   import i2cbb_pkg::*;

   typedef enum logic [15:0] {
      PH_IDLE = 16'h0001,
      PH_ST1  = 16'h0002,
      PH_ST2  = 16'h0004,
      PH_SP1  = 16'h0008,
      PH_SP2  = 16'h0010,
      PH_WR0  = 16'h0020,
      PH_WR1  = 16'h0040,
      PH_WR2  = 16'h0080,
      PH_RD0  = 16'h0100,
      PH_RD1  = 16'h0200,
      PH_RA0  = 16'h0400,
      PH_RA1  = 16'h0800,
      PH_WK0  = 16'h1000,
      PH_WK1  = 16'h2000,
      PH_WK2  = 16'h4000,
      PH_WK3  = 16'h8000
   } phase_type;

   localparam logic [BIT_INDEX_WIDTH-1:0] LAST_BIT = BIT_INDEX_WIDTH'(BITS_PER_BYTE - 1);
   localparam logic [BIT_INDEX_WIDTH-1:0] NUM_BITS = BIT_INDEX_WIDTH'(BITS_PER_BYTE);

   logic [15:0] bit_half_ff, start_stop_ff, ack_setup_ff;
   logic [7:0]  retry_limit_ff;

   phase_type                  phase_ff, phase_in;
   tick_type                   tick_ff, tick_in;
   logic [BIT_INDEX_WIDTH-1:0] bit_ff, bit_in;
   logic [BITS_PER_BYTE-1:0]   shift_ff, shift_in;
   logic [7:0]                 retry_ff, retry_in;
   logic                       ack_mode_ff, ack_mode_in;
   logic                       scl_ff, scl_in;
   logic                       sda_ff, sda_in;
   logic                       ack_flag_ff, ack_flag_in;
   logic [BITS_PER_BYTE-1:0]   rx_ff, rx_in;
   logic                       done;

   logic                       rsp_valid_ff;
   i2cbb_rsp_type              rsp_data_ff;
   logic                       accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      logic [BIT_INDEX_WIDTH-1:0] bit_nx;
      logic [BITS_PER_BYTE-1:0]   shift_nx;
      tick_type                   tick_dec;
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      retry_in    = retry_ff;
      ack_mode_in = ack_mode_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      ack_flag_in = ack_flag_ff;
      rx_in       = rx_ff;
      done        = 1'b0;
      bit_nx      = bit_ff + BIT_INDEX_WIDTH'(1);
      shift_nx    = {shift_ff[BITS_PER_BYTE-2:0], 1'b0};
      tick_dec    = tick_ff - TICK_COUNTER_WIDTH'(1);
      if (phase_ff == PH_IDLE) begin
         if (req_data.cmd_valid) begin
            case (req_data.opcode)
               OP_START: begin
                  sda_in   = 1'b1;
                  scl_in   = 1'b1;
                  phase_in = PH_ST1;
                  tick_in  = delay_of(start_stop_ff);
               end
               OP_STOP: begin
                  sda_in   = 1'b0;
                  scl_in   = 1'b0;
                  phase_in = PH_SP1;
                  tick_in  = delay_of(start_stop_ff);
               end
               OP_WRITE: begin
                  shift_in = req_data.tx_byte;
                  bit_in   = '0;
                  sda_in   = req_data.tx_byte[BITS_PER_BYTE-1];
                  phase_in = PH_WR0;
                  tick_in  = delay_of(bit_half_ff);
               end
               OP_READ: begin
                  ack_mode_in = req_data.send_ack;
                  shift_in    = '0;
                  bit_in      = '0;
                  sda_in      = 1'b1;
                  scl_in      = 1'b0;
                  phase_in    = PH_RD0;
                  tick_in     = delay_of(bit_half_ff);
               end
               OP_WAIT_ACK: begin
                  sda_in      = 1'b1;
                  ack_flag_in = 1'b0;
                  retry_in    = retry_limit_ff;
                  phase_in    = PH_WK0;
                  tick_in     = delay_of(ack_setup_ff);
               end
               default: begin
               end
            endcase
         end
      end else begin
         tick_in = tick_dec;
         if (tick_dec == '0) begin
            case (phase_ff)
               PH_ST1: begin
                  sda_in   = 1'b0;
                  phase_in = PH_ST2;
                  tick_in  = delay_of(start_stop_ff);
               end
               PH_ST2: begin
                  scl_in = 1'b0;
                  done   = 1'b1;
               end
               PH_SP1: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
                  phase_in = PH_SP2;
                  tick_in  = delay_of(start_stop_ff);
               end
               PH_SP2: begin
                  done = 1'b1;
               end
               PH_WR0: begin
                  scl_in   = 1'b1;
                  phase_in = PH_WR1;
                  tick_in  = delay_of(bit_half_ff);
               end
               PH_WR1: begin
                  scl_in = 1'b0;
                  if (bit_ff == LAST_BIT) begin
                     sda_in = 1'b1;
                  end
                  phase_in = PH_WR2;
                  tick_in  = delay_of(bit_half_ff);
               end
               PH_WR2: begin
                  shift_in = shift_nx;
                  bit_in   = bit_nx;
                  if (bit_nx < NUM_BITS) begin
                     sda_in   = shift_nx[BITS_PER_BYTE-1];
                     phase_in = PH_WR0;
                     tick_in  = delay_of(bit_half_ff);
                  end else begin
                     done = 1'b1;
                  end
               end
               PH_RD0: begin
                  scl_in   = 1'b1;
                  phase_in = PH_RD1;
                  tick_in  = delay_of(bit_half_ff);
               end
               PH_RD1: begin
                  shift_in = {shift_ff[BITS_PER_BYTE-2:0], req_data.sda_sample};
                  bit_in   = bit_nx;
                  scl_in   = 1'b0;
                  tick_in  = delay_of(bit_half_ff);
                  if (bit_nx < NUM_BITS) begin
                     phase_in = PH_RD0;
                  end else begin
                     rx_in    = {shift_ff[BITS_PER_BYTE-2:0], req_data.sda_sample};
                     sda_in   = !ack_mode_ff;
                     phase_in = PH_RA0;
                  end
               end
               PH_RA0: begin
                  scl_in   = 1'b1;
                  phase_in = PH_RA1;
                  tick_in  = delay_of(bit_half_ff);
               end
               PH_RA1: begin
                  scl_in = 1'b0;
                  done   = 1'b1;
               end
               PH_WK0: begin
                  scl_in   = 1'b1;
                  phase_in = PH_WK1;
                  tick_in  = delay_of(ack_setup_ff);
               end
               PH_WK1, PH_WK3: begin
                  scl_in = 1'b0;
                  if (retry_ff == '0) begin
                     done = 1'b1;
                  end else begin
                     retry_in = retry_ff - 8'd1;
                     if (req_data.sda_sample) begin
                        phase_in = PH_WK2;
                        tick_in  = delay_of(start_stop_ff);
                     end else begin
                        ack_flag_in = 1'b1;
                        done        = 1'b1;
                     end
                  end
               end
               PH_WK2: begin
                  scl_in   = 1'b1;
                  phase_in = PH_WK3;
                  tick_in  = delay_of(start_stop_ff);
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
            if (done) begin
               phase_in = PH_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_half_ff    <= BIT_HALF_RESET;
         start_stop_ff  <= START_STOP_RESET;
         ack_setup_ff   <= ACK_SETUP_RESET;
         retry_limit_ff <= RETRY_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CFG_BIT_HALF:    bit_half_ff    <= csr_wdata;
            CFG_START_STOP:  start_stop_ff  <= csr_wdata;
            CFG_ACK_SETUP:   ack_setup_ff   <= csr_wdata;
            CFG_RETRY_LIMIT: retry_limit_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         retry_ff     <= '0;
         ack_mode_ff  <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_flag_ff  <= 1'b0;
         rx_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            tick_ff     <= tick_in;
            bit_ff      <= bit_in;
            shift_ff    <= shift_in;
            retry_ff    <= retry_in;
            ack_mode_ff <= ack_mode_in;
            scl_ff      <= scl_in;
            sda_ff      <= sda_in;
            ack_flag_ff <= ack_flag_in;
            rx_ff       <= rx_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response beat payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff.scl_level <= scl_in;
         rsp_data_ff.sda_level <= sda_in;
         rsp_data_ff.busy_res  <= (phase_in != PH_IDLE);
         rsp_data_ff.cmd_done  <= done;
         rsp_data_ff.rx_byte   <= rx_in;
         rsp_data_ff.ack_seen  <= ack_flag_in;
      end
   end

endmodule

>>> tb/tb.sv
// Testbench for the bit-banged I2C master: per-tick prediction of line levels and status.
`timescale 1ns / 1ps

module tb;
   import i2cbb_pkg::*;

   typedef enum logic [3:0] {
      SEG_IDLE,
      SEG_START_HOLD,
      SEG_START_LOW,
      SEG_STOP_HOLD,
      SEG_STOP_HIGH,
      SEG_WR_LOW,
      SEG_WR_HIGH,
      SEG_WR_TAIL,
      SEG_RD_LOW,
      SEG_RD_HIGH,
      SEG_ACK_LOW,
      SEG_ACK_HIGH,
      SEG_WA_SETUP,
      SEG_WA_CHECK,
      SEG_WA_PULSE_LOW,
      SEG_WA_PULSE_HIGH
   } seg_type;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   i2cbb_req_type              req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   i2cbb_rsp_type              rsp_data;
   logic                       csr_we    = 1'b0;
   logic [CFG_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CFG_DATA_WIDTH-1:0]  csr_wdata = '0;

   // line sequencer shadow
   logic [15:0]   cfg_bit_half;
   logic [15:0]   cfg_start_stop;
   logic [15:0]   cfg_ack_setup;
   logic [7:0]    cfg_retry_limit;
   seg_type       seg;
   tick_type      seg_ticks;
   logic [3:0]    bit_pos;
   logic [7:0]    shift_byte;
   logic [7:0]    retries_left;
   logic [7:0]    rx_last;
   logic          ack_after_read;
   logic          scl_out;
   logic          sda_out;
   logic          ack_got;

   i2cbb_rsp_type line_status_q[$];

   int  mismatches    = 0;
   int  beats_sent    = 0;
   int  cmds_finished = 0;
   int  acks_seen     = 0;
   int  csr_writes    = 0;
   int  rx_hold_cycles = 0;
   int  hold_offs     = 0;
   bit  gap_en        = 1'b1;
   bit  stall_en      = 1'b1;

   i2c_bitbang_master_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(200_000_000);
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) begin
         $display("tb: mismatch at %0t: %s", $time, what);
      end
   endtask

   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(8, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic logic draw_sda(input int high_pct);
      return $urandom_range(0, 99) < high_pct;
   endfunction

   function automatic i2cbb_req_type make_beat(input logic v, input logic [2:0] op,
                                               input logic [7:0] tx, input logic ak,
                                               input logic sda);
      i2cbb_req_type r;
      r.cmd_valid  = v;
      r.opcode     = op;
      r.tx_byte    = tx;
      r.send_ack   = ak;
      r.sda_sample = sda;
      return r;
   endfunction

   // ---------------- predictor ----------------

   function automatic tick_type seg_length(input logic [15:0] d);
      return (d == '0) ? tick_type'(1) : tick_type'(d);
   endfunction

   task automatic enter_seg(input seg_type s, input logic [15:0] d);
      seg       = s;
      seg_ticks = seg_length(d);
   endtask

   task automatic predictor_reset();
      cfg_bit_half    = 16'd100;
      cfg_start_stop  = 16'd200;
      cfg_ack_setup   = 16'd50;
      cfg_retry_limit = 8'd250;
      seg             = SEG_IDLE;
      seg_ticks       = '0;
      bit_pos         = '0;
      shift_byte      = '0;
      retries_left    = '0;
      rx_last         = '0;
      ack_after_read  = 1'b0;
      scl_out         = 1'b1;
      sda_out         = 1'b1;
      ack_got         = 1'b0;
   endtask

   // current segment has run out; fin set when the command completes
   task automatic seg_expire(input logic sda_in, output logic fin);
      fin = 1'b0;
      case (seg)
         SEG_START_HOLD: begin
            sda_out = 1'b0;
            enter_seg(SEG_START_LOW, cfg_start_stop);
         end
         SEG_START_LOW: begin
            scl_out = 1'b0;
            fin = 1'b1;
         end
         SEG_STOP_HOLD: begin
            scl_out = 1'b1;
            sda_out = 1'b1;
            enter_seg(SEG_STOP_HIGH, cfg_start_stop);
         end
         SEG_STOP_HIGH: fin = 1'b1;
         SEG_WR_LOW: begin
            scl_out = 1'b1;
            enter_seg(SEG_WR_HIGH, cfg_bit_half);
         end
         SEG_WR_HIGH: begin
            scl_out = 1'b0;
            if (bit_pos == BITS_PER_BYTE - 1) sda_out = 1'b1;
            enter_seg(SEG_WR_TAIL, cfg_bit_half);
         end
         SEG_WR_TAIL: begin
            shift_byte = shift_byte << 1;
            bit_pos    = bit_pos + 1'b1;
            if (bit_pos < BITS_PER_BYTE) begin
               sda_out = shift_byte[7];
               enter_seg(SEG_WR_LOW, cfg_bit_half);
            end else begin
               fin = 1'b1;
            end
         end
         SEG_RD_LOW: begin
            scl_out = 1'b1;
            enter_seg(SEG_RD_HIGH, cfg_bit_half);
         end
         SEG_RD_HIGH: begin
            shift_byte = {shift_byte[6:0], sda_in};
            bit_pos    = bit_pos + 1'b1;
            scl_out    = 1'b0;
            if (bit_pos < BITS_PER_BYTE) begin
               enter_seg(SEG_RD_LOW, cfg_bit_half);
            end else begin
               rx_last = shift_byte;
               sda_out = ~ack_after_read;
               enter_seg(SEG_ACK_LOW, cfg_bit_half);
            end
         end
         SEG_ACK_LOW: begin
            scl_out = 1'b1;
            enter_seg(SEG_ACK_HIGH, cfg_bit_half);
         end
         SEG_ACK_HIGH: begin
            scl_out = 1'b0;
            fin = 1'b1;
         end
         SEG_WA_SETUP: begin
            scl_out = 1'b1;
            enter_seg(SEG_WA_CHECK, cfg_ack_setup);
         end
         SEG_WA_CHECK, SEG_WA_PULSE_HIGH: begin
            scl_out = 1'b0;
            if (retries_left == '0) begin
               fin = 1'b1;
            end else begin
               retries_left = retries_left - 1'b1;
               if (sda_in) begin
                  enter_seg(SEG_WA_PULSE_LOW, cfg_start_stop);
               end else begin
                  ack_got = 1'b1;
                  fin = 1'b1;
               end
            end
         end
         SEG_WA_PULSE_LOW: begin
            scl_out = 1'b1;
            enter_seg(SEG_WA_PULSE_HIGH, cfg_start_stop);
         end
         default: seg = SEG_IDLE;
      endcase
   endtask

   task automatic predict_line_tick(input i2cbb_req_type r, output i2cbb_rsp_type o);
      logic fin;
      fin = 1'b0;
      if (seg == SEG_IDLE) begin
         if (r.cmd_valid) begin
            case (r.opcode)
               OP_START: begin
                  sda_out = 1'b1;
                  scl_out = 1'b1;
                  enter_seg(SEG_START_HOLD, cfg_start_stop);
               end
               OP_STOP: begin
                  scl_out = 1'b0;
                  sda_out = 1'b0;
                  enter_seg(SEG_STOP_HOLD, cfg_start_stop);
               end
               OP_WRITE: begin
                  shift_byte = r.tx_byte;
                  bit_pos    = '0;
                  sda_out    = r.tx_byte[7];
                  enter_seg(SEG_WR_LOW, cfg_bit_half);
               end
               OP_READ: begin
                  ack_after_read = r.send_ack;
                  shift_byte     = '0;
                  bit_pos        = '0;
                  sda_out        = 1'b1;
                  scl_out        = 1'b0;
                  enter_seg(SEG_RD_LOW, cfg_bit_half);
               end
               OP_WAIT_ACK: begin
                  sda_out      = 1'b1;
                  ack_got      = 1'b0;
                  retries_left = cfg_retry_limit;
                  enter_seg(SEG_WA_SETUP, cfg_ack_setup);
               end
               default: ;
            endcase
         end
      end else begin
         seg_ticks = seg_ticks - 1'b1;
         if (seg_ticks == '0) begin
            seg_expire(r.sda_sample, fin);
            if (fin) seg = SEG_IDLE;
         end
      end
      o.scl_level = scl_out;
      o.sda_level = sda_out;
      o.busy_res  = (seg != SEG_IDLE);
      o.cmd_done  = fin;
      o.rx_byte   = rx_last;
      o.ack_seen  = ack_got;
   endtask

   // ---------------- drivers ----------------

   task automatic send_beat(input i2cbb_req_type r);
      int gap;
      i2cbb_rsp_type e;
      gap = (gap_en && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predict_line_tick(r, e);
      line_status_q.push_back(e);
      beats_sent++;
      @(negedge clock);
   endtask

   // issue one command and tick until it completes; busy beats carry noise commands
   task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ak,
                          input int high_pct);
      send_beat(make_beat(1'b1, op, tx, ak, draw_sda(high_pct)));
      while (seg != SEG_IDLE) begin
         send_beat(make_beat(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                             8'($urandom), 1'($urandom_range(0, 1)), draw_sda(high_pct)));
      end
   endtask

   task automatic drain_bus();
      int waited;
      while (seg != SEG_IDLE) begin
         send_beat(make_beat(1'b0, 3'($urandom_range(0, 7)), 8'($urandom),
                             1'($urandom_range(0, 1)), draw_sda(50)));
      end
      req_valid <= 1'b0;
      waited = 0;
      do begin
         @(negedge clock);
         waited++;
      end while (line_status_q.size() != 0 && waited < 200000);
      if (line_status_q.size() != 0) begin
         report_mismatch($sformatf("%0d expected beats never arrived", line_status_q.size()));
         line_status_q.delete();
      end
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input cfg_index_type idx, input logic [15:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CFG_BIT_HALF:    cfg_bit_half    = v;
         CFG_START_STOP:  cfg_start_stop  = v;
         CFG_ACK_SETUP:   cfg_ack_setup   = v;
         CFG_RETRY_LIMIT: cfg_retry_limit = v[7:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // ---------------- response side ----------------

   initial begin : rsp_stall
      forever begin
         @(negedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rx_hold_cycles) @(negedge clock);
            rx_hold_cycles = 0;
            hold_offs++;
            rsp_ready <= 1'b1;
         end else if (stall_en && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap()) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin : rsp_check
      i2cbb_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_status_q.size() == 0) begin
            report_mismatch("response beat with nothing expected");
         end else begin
            want = line_status_q.pop_front();
            check_field("scl_level", 8'(rsp_data.scl_level), 8'(want.scl_level));
            check_field("sda_level", 8'(rsp_data.sda_level), 8'(want.sda_level));
            check_field("busy_res",  8'(rsp_data.busy_res),  8'(want.busy_res));
            check_field("cmd_done",  8'(rsp_data.cmd_done),  8'(want.cmd_done));
            check_field("rx_byte",   rsp_data.rx_byte,       want.rx_byte);
            check_field("ack_seen",  8'(rsp_data.ack_seen),  8'(want.ack_seen));
            if (want.cmd_done) cmds_finished++;
            if (want.cmd_done && want.ack_seen) acks_seen++;
         end
      end
   end

   // ---------------- tests ----------------

   // register values straight out of reset
   task automatic test_reset_timing();
      send_beat(make_beat(1'b0, OP_START, 8'h00, 1'b0, 1'b1));
      run_cmd(OP_START, 8'h00, 1'b0, 50);
      run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 0);
      drain_bus();
   endtask

   task automatic test_directed_ops();
      write_reg(CFG_BIT_HALF, 16'd1);
      write_reg(CFG_START_STOP, 16'd2);
      write_reg(CFG_ACK_SETUP, 16'd1);
      write_reg(CFG_RETRY_LIMIT, 16'd3);
      run_cmd(OP_START, 8'h00, 1'b0, 50);
      run_cmd(OP_WRITE, 8'hFF, 1'b0, 50);
      run_cmd(OP_WRITE, 8'h00, 1'b1, 50);
      run_cmd(OP_WRITE, 8'h80, 1'b0, 50);
      run_cmd(OP_WRITE, 8'h01, 1'b1, 50);
      run_cmd(OP_READ, 8'h00, 1'b1, 100);
      run_cmd(OP_READ, 8'hFF, 1'b0, 0);
      run_cmd(OP_READ, 8'h55, 1'b1, 50);
      run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 100);   // retries run out
      run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 0);
      run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 60);
      run_cmd(3'd5, 8'hAA, 1'b1, 50);           // unused opcodes: stays idle
      run_cmd(3'd6, 8'h55, 1'b0, 50);
      run_cmd(3'd7, 8'hFF, 1'b1, 50);
      send_beat(make_beat(1'b0, OP_WRITE, 8'h12, 1'b1, 1'b0));
      run_cmd(OP_STOP, 8'h00, 1'b0, 50);
      drain_bus();
   endtask

   task automatic test_config_corners();
      write_reg(CFG_BIT_HALF, 16'd1);
      write_reg(CFG_START_STOP, 16'd1);
      write_reg(CFG_ACK_SETUP, 16'd1);
      write_reg(CFG_RETRY_LIMIT, 16'd0);
      run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 0);     // zero limit: no ack even with SDA low
      drain_bus();
      write_reg(CFG_RETRY_LIMIT, 16'h00FF);
      run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 97);
      drain_bus();
      write_reg(CFG_BIT_HALF, 16'd0);           // zero delays last one tick
      write_reg(CFG_START_STOP, 16'd0);
      write_reg(CFG_ACK_SETUP, 16'd0);
      run_cmd(OP_START, 8'h00, 1'b0, 50);
      run_cmd(OP_WRITE, 8'($urandom), 1'b0, 50);
      run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 80);
      run_cmd(OP_READ, 8'h00, 1'b0, 50);
      run_cmd(OP_STOP, 8'h00, 1'b0, 50);
      drain_bus();
      gap_en   = 1'b0;
      stall_en = 1'b0;
      write_reg(CFG_BIT_HALF, 16'd9);           // longer segments
      run_cmd(OP_WRITE, 8'h5A, 1'b0, 50);
      drain_bus();
      write_reg(CFG_BIT_HALF, 16'd1);
      write_reg(CFG_START_STOP, 16'd20);
      run_cmd(OP_STOP, 8'h00, 1'b0, 50);
      drain_bus();
      write_reg(CFG_START_STOP, 16'd1);
      write_reg(CFG_ACK_SETUP, 16'd20);
      run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 0);
      drain_bus();
      gap_en   = 1'b1;
      stall_en = 1'b1;
   endtask

   // consumer stalls for a long stretch while offered beats wait on req_ready, then a full pause
   task automatic test_output_hold_off();
      write_reg(CFG_BIT_HALF, 16'd2);
      write_reg(CFG_START_STOP, 16'd1);
      write_reg(CFG_ACK_SETUP, 16'd1);
      write_reg(CFG_RETRY_LIMIT, 16'd4);
      gap_en = 1'b0;
      rx_hold_cycles = 300;
      run_cmd(OP_WRITE, 8'h3C, 1'b0, 50);
      repeat (4) run_cmd(OP_READ, 8'h00, 1'($urandom_range(0, 1)), 50);
      drain_bus();
      gap_en = 1'b1;
   endtask

   task automatic run_transfer();
      logic [7:0] addr;
      int         n;
      addr = 8'($urandom);
      n    = $urandom_range(0, 3);
      run_cmd(OP_START, 8'($urandom), 1'($urandom_range(0, 1)), 50);
      run_cmd(OP_WRITE, addr, 1'($urandom_range(0, 1)), 50);
      run_cmd(OP_WAIT_ACK, 8'($urandom), 1'($urandom_range(0, 1)), 30);
      for (int i = 0; i < n; i++) begin
         if (addr[0]) begin
            run_cmd(OP_READ, 8'($urandom), (i != n - 1), 50);
         end else begin
            run_cmd(OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), 50);
            run_cmd(OP_WAIT_ACK, 8'($urandom), 1'($urandom_range(0, 1)), 30);
         end
      end
      if ($urandom_range(0, 9) != 0) run_cmd(OP_STOP, 8'($urandom), 1'b0, 50);
   endtask

   // random traffic tops the run up to its total beat count
   task automatic test_random_traffic();
      int goal;
      int epoch_start;
      goal = 1950;
      while (beats_sent < goal) begin
         drain_bus();
         write_reg(CFG_BIT_HALF,
                   ($urandom_range(0, 9) == 0) ? 16'($urandom_range(4, 12))
                                               : 16'($urandom_range(0, 2)));
         write_reg(CFG_START_STOP,
                   ($urandom_range(0, 9) == 0) ? 16'($urandom_range(4, 12))
                                               : 16'($urandom_range(0, 2)));
         write_reg(CFG_ACK_SETUP, 16'($urandom_range(0, 3)));
         write_reg(CFG_RETRY_LIMIT,
                   ($urandom_range(0, 9) == 0) ? 16'd255 : 16'($urandom_range(0, 4)));
         gap_en      = ($urandom_range(0, 3) != 0);
         stall_en    = ($urandom_range(0, 3) != 0);
         epoch_start = beats_sent;
         while (beats_sent - epoch_start < 150 && beats_sent < goal) begin
            if ($urandom_range(0, 9) < 7) begin
               run_transfer();
            end else begin
               run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 100));
            end
         end
      end
   endtask

   initial begin
      predictor_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_timing();
      test_directed_ops();
      test_config_corners();
      test_output_hold_off();
      test_random_traffic();
      drain_bus();
      $display("tb: %0d tick beats, %0d commands completed, %0d acknowledges, %0d csr writes",
               beats_sent, cmds_finished, acks_seen, csr_writes);
      $display("tb: covered all opcodes, zero and longer delays, zero retry limit, %0d hold-off",
               hold_offs);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> i2c_bitbang_master_unit.f
rtl/i2cbb_pkg.sv
rtl/i2c_bitbang_master_unit.sv
tb/tb.sv
